### design/gdvcd_pkg.sv
// ----------------------------------------------------------------------------
// gdvcd_pkg: shared types, constants and calendar functions
// Field widths, reciprocal constants and month tables used by the date
// pipeline and its control.
// ----------------------------------------------------------------------------
package gdvcd_pkg;

    // field widths
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int MLEN_W   = 5;
    localparam int ORDER_W  = 2;
    localparam int DIFF_W   = 22;
    localparam int SERIAL_W = 23;
    localparam int MOFF_W   = 9;
    localparam int Q100_W   = 8;
    localparam int YY_W     = 15;

    // packed stream widths
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 40;

    // default upper bound on a valid year
    localparam int MAX_YEAR_DEF = 9999;

    // year offset that keeps the march-based year non-negative
    localparam int YEAR_BIAS = 400;

    // divide by 100 as multiply by ceil(2^19 / 100) then shift, exact below 43690
    localparam int RECIP100       = 5243;
    localparam int RECIP100_SHIFT = 19;

    localparam int DAYS_PER_YEAR = 365;

    // order codes
    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'b01;
    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'b11;

    // pipeline stage enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic out;
    } pipe_en_t;

    // days in a month, february (and any out-of-range month) by leap rule
    function automatic logic [MLEN_W-1:0] month_len_f(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [MLEN_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            default:                                    len = leap ? 5'd29 : 5'd28;
        endcase
        return len;
    endfunction

    // days before the month in a march-based year: (153 * ((m + 9) % 12) + 2) / 5
    function automatic logic [MOFF_W-1:0] month_offset_f(input logic [MONTH_W-1:0] m);
        logic [MOFF_W-1:0] off;
        case (m)
            4'd0:    off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd13:   off = 9'd306;
            4'd14:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

### design/gdvcd_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// gdvcd_pipe_ctrl: stage valid bits and stall control
// Keeps one valid bit per stage; a stage loads when it is empty or when the
// stage after it moves, so bubbles are squeezed out under backpressure.
// ----------------------------------------------------------------------------
module gdvcd_pipe_ctrl
    import gdvcd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output pipe_en_t en
);

    logic v1_reg, v2_reg, v3_reg, vout_reg;

    // stage enables, back to front
    always_comb begin
        en.out = !vout_reg || m_tready;
        en.s3  = !v3_reg || en.out;
        en.s2  = !v2_reg || en.s3;
        en.s1  = !v1_reg || en.s2;
    end

    assign s_tready = en.s1;
    assign m_tvalid = vout_reg;

    // valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else begin
            if (en.s1)  v1_reg   <= s_tvalid;
            if (en.s2)  v2_reg   <= v1_reg;
            if (en.s3)  v3_reg   <= v2_reg;
            if (en.out) vout_reg <= v3_reg;
        end
    end

endmodule

### design/gdvcd_date_unit.sv
// ----------------------------------------------------------------------------
// gdvcd_date_unit: three-stage date evaluation
// Checks one date, finds its leap flag and month length, and builds its day
// serial number: divide by 100 in stage 1, leap and year days in stage 2,
// serial sum in stage 3.
// ----------------------------------------------------------------------------
module gdvcd_date_unit
    import gdvcd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic                aclk,
    input  pipe_en_t            en,
    input  logic [DAY_W-1:0]    day,
    input  logic [MONTH_W-1:0]  month,
    input  logic [YEAR_W-1:0]   year,
    output logic                valid,
    output logic                leap,
    output logic [MLEN_W-1:0]   month_len,
    output logic [SERIAL_W-1:0] serial
);

    localparam int YPROD_W  = YEAR_W + 13;
    localparam int YYPROD_W = YY_W + 13;

    // stage 1 signals
    logic [YPROD_W-1:0]  y_prod;
    logic [YY_W-1:0]     yy_next;
    logic [YYPROD_W-1:0] yy_prod;
    logic                year_ok_next;
    logic                month_ok_next;

    logic [DAY_W-1:0]    day1_reg;
    logic [MONTH_W-1:0]  month1_reg;
    logic [YEAR_W-1:0]   year1_reg;
    logic [Q100_W-1:0]   yq1_reg;
    logic [YY_W-1:0]     yy1_reg;
    logic [Q100_W-1:0]   yyq1_reg;
    logic [MOFF_W-1:0]   moff1_reg;
    logic                year_ok1_reg;
    logic                month_ok1_reg;

    // stage 2 signals
    logic [6:0]          rem100;
    logic                leap_next;
    logic [MLEN_W-1:0]   mlen_next;
    logic                valid_next;
    logic [SERIAL_W-1:0] base_next;

    logic                leap2_reg;
    logic [MLEN_W-1:0]   mlen2_reg;
    logic                valid2_reg;
    logic [SERIAL_W-1:0] base2_reg;
    logic [Q100_W-1:0]   yyq2_reg;
    logic [MOFF_W-1:0]   moff2_reg;
    logic [DAY_W-1:0]    day2_reg;

    // stage 3 signals
    logic [SERIAL_W-1:0] serial_next;
    logic                leap3_reg;
    logic [MLEN_W-1:0]   mlen3_reg;
    logic                valid3_reg;
    logic [SERIAL_W-1:0] serial3_reg;

    // stage 1: quotients by 100 of the year and the march-based biased year
    always_comb begin
        y_prod        = YPROD_W'(year) * YPROD_W'(RECIP100);
        yy_next       = YY_W'(year) + YY_W'(YEAR_BIAS) - YY_W'(month <= MONTH_W'(2));
        yy_prod       = YYPROD_W'(yy_next) * YYPROD_W'(RECIP100);
        year_ok_next  = 32'(year) <= 32'(MAX_YEAR);
        month_ok_next = (month >= MONTH_W'(1)) && (month <= MONTH_W'(12));
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            day1_reg      <= day;
            month1_reg    <= month;
            year1_reg     <= year;
            yq1_reg       <= y_prod[RECIP100_SHIFT +: Q100_W];
            yy1_reg       <= yy_next;
            yyq1_reg      <= yy_prod[RECIP100_SHIFT +: Q100_W];
            moff1_reg     <= month_offset_f(month);
            year_ok1_reg  <= year_ok_next;
            month_ok1_reg <= month_ok_next;
        end
    end

    // stage 2: leap rule, month length, validity and whole-year days
    always_comb begin
        rem100     = 7'(year1_reg - YEAR_W'(yq1_reg) * YEAR_W'(100));
        // divisible by 4 but not 100, or divisible by 100 with quotient divisible by 4
        leap_next  = ((year1_reg[1:0] == 2'b00) && (rem100 != 7'd0)) ||
                     ((rem100 == 7'd0) && (yq1_reg[1:0] == 2'b00));
        mlen_next  = month_len_f(month1_reg, leap_next);
        valid_next = year_ok1_reg && month_ok1_reg && (day1_reg != DAY_W'(0)) &&
                     (day1_reg <= mlen_next);
        base_next  = SERIAL_W'(yy1_reg) * SERIAL_W'(DAYS_PER_YEAR) +
                     SERIAL_W'(yy1_reg >> 2);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            leap2_reg  <= leap_next;
            mlen2_reg  <= mlen_next;
            valid2_reg <= valid_next;
            base2_reg  <= base_next;
            yyq2_reg   <= yyq1_reg;
            moff2_reg  <= moff1_reg;
            day2_reg   <= day1_reg;
        end
    end

    // stage 3: century corrections, month offset and day
    always_comb begin
        serial_next = base2_reg - SERIAL_W'(yyq2_reg) + SERIAL_W'(yyq2_reg >> 2) +
                      SERIAL_W'(moff2_reg) + SERIAL_W'(day2_reg);
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            leap3_reg   <= leap2_reg;
            mlen3_reg   <= mlen2_reg;
            valid3_reg  <= valid2_reg;
            serial3_reg <= serial_next;
        end
    end

    assign valid     = valid3_reg;
    assign leap      = leap3_reg;
    assign month_len = mlen3_reg;
    assign serial    = serial3_reg;

endmodule

### design/gregorian_date_validate_compare_diff.sv
// ----------------------------------------------------------------------------
// gregorian_date_validate_compare_diff: date check, compare and day distance
// Throughput: one pair of dates per cycle; every stage takes a new transaction
// each cycle, and only m_tready holding off stalls the four-stage pipeline.
// Reset: aresetn synchronous active low clears all stage valid bits;
// payload registers are not reset.
// ----------------------------------------------------------------------------
module gregorian_date_validate_compare_diff
    import gdvcd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23] month_b[31:28] year_b[45:32]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // valid_a[0] valid_b[1] leap_a[2] leap_b[3] month_len_a[8:4] month_len_b[13:9]
    // order[15:14] day_difference[37:16]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready
);

    pipe_en_t en;

    logic [DAY_W-1:0]   day_a, day_b;
    logic [MONTH_W-1:0] month_a, month_b;
    logic [YEAR_W-1:0]  year_a, year_b;

    logic                valid_a, valid_b, leap_a, leap_b;
    logic [MLEN_W-1:0]   month_len_a, month_len_b;
    logic [SERIAL_W-1:0] serial_a, serial_b;

    logic [ORDER_W-1:0] order_next;
    logic [ORDER_W-1:0] order1_reg, order2_reg, order3_reg;

    logic [SERIAL_W-1:0] serial_gap;
    logic [DIFF_W-1:0]   diff_next;

    logic                valid_a_reg, valid_b_reg, leap_a_reg, leap_b_reg;
    logic [MLEN_W-1:0]   month_len_a_reg, month_len_b_reg;
    logic [ORDER_W-1:0]  order_reg;
    logic [DIFF_W-1:0]   diff_reg;

    // unpack input transaction
    assign day_a   = s_tdata[4:0];
    assign month_a = s_tdata[8:5];
    assign year_a  = s_tdata[22:9];
    assign day_b   = s_tdata[27:23];
    assign month_b = s_tdata[31:28];
    assign year_b  = s_tdata[45:32];

    gdvcd_pipe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .en       (en)
    );

    gdvcd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_date_a (
        .aclk      (aclk),
        .en        (en),
        .day       (day_a),
        .month     (month_a),
        .year      (year_a),
        .valid     (valid_a),
        .leap      (leap_a),
        .month_len (month_len_a),
        .serial    (serial_a)
    );

    gdvcd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_date_b (
        .aclk      (aclk),
        .en        (en),
        .day       (day_b),
        .month     (month_b),
        .year      (year_b),
        .valid     (valid_b),
        .leap      (leap_b),
        .month_len (month_len_b),
        .serial    (serial_b)
    );

    // three-way order on the raw year, month, day fields
    always_comb begin
        if ({year_a, month_a, day_a} > {year_b, month_b, day_b}) begin
            order_next = ORDER_LATER;
        end else if ({year_a, month_a, day_a} < {year_b, month_b, day_b}) begin
            order_next = ORDER_EARLIER;
        end else begin
            order_next = ORDER_EQUAL;
        end
    end

    // order rides alongside the date units
    always_ff @(posedge aclk) begin
        if (en.s1) order1_reg <= order_next;
        if (en.s2) order2_reg <= order1_reg;
        if (en.s3) order3_reg <= order2_reg;
    end

    // absolute distance, saturated, zero unless both dates are valid
    always_comb begin
        serial_gap = (serial_a >= serial_b) ? (serial_a - serial_b) : (serial_b - serial_a);
        if (!(valid_a && valid_b)) begin
            diff_next = '0;
        end else if (serial_gap[SERIAL_W-1]) begin
            diff_next = '1;
        end else begin
            diff_next = serial_gap[DIFF_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en.out) begin
            valid_a_reg     <= valid_a;
            valid_b_reg     <= valid_b;
            leap_a_reg      <= leap_a;
            leap_b_reg      <= leap_b;
            month_len_a_reg <= month_len_a;
            month_len_b_reg <= month_len_b;
            order_reg       <= order3_reg;
            diff_reg        <= diff_next;
        end
    end

    assign m_tdata = {2'b00, diff_reg, order_reg, month_len_b_reg, month_len_a_reg,
                      leap_b_reg, leap_a_reg, valid_b_reg, valid_a_reg};

    // a nonzero distance needs two valid dates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (diff_reg == '0) || (valid_a_reg && valid_b_reg))
        else $error("day distance nonzero with an invalid date");

    // equal dates are zero days apart
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (order_reg == ORDER_EQUAL) |-> (diff_reg == '0))
        else $error("equal dates give nonzero distance");

    // a valid date has a month length of 28 to 31 days
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && valid_a_reg |-> (month_len_a_reg >= MLEN_W'(28)) &&
                                    (month_len_a_reg <= MLEN_W'(31)))
        else $error("month length out of range for a valid date");

    // order code is never the unused pattern
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (order_reg != 2'b10))
        else $error("illegal order code");

endmodule
